[hw/rtl/chgw_pkg.sv]
// ----------------------------------------------------------------------------
// chgw_pkg
// Shared constants for the gift-wrapping convex hull block.
// ----------------------------------------------------------------------------
package chgw_pkg;

   // Multiplier bits consumed per cycle by the serial product unit.
   localparam int MUL_DIGIT = 8;

   // Width of the load-order index on the result channel.
   localparam int VERTEX_INDEX_BITS = 6;

endpackage

[hw/rtl/chgw_mul.sv]
// ----------------------------------------------------------------------------
// chgw_mul
// Unsigned serial multiplier, MUL_DIGIT bits of the second operand per cycle.
// ----------------------------------------------------------------------------
module chgw_mul #(
   parameter int A_BITS = 68,
   parameter int B_BITS = 34
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [A_BITS-1:0]          a,
   input  logic [B_BITS-1:0]          b,
   output logic                       done,
   output logic [A_BITS+B_BITS-1:0]   prod
);
   import chgw_pkg::*;

   localparam int P_BITS = A_BITS + B_BITS;
   localparam int STEPS  = (B_BITS + MUL_DIGIT - 1) / MUL_DIGIT;
   localparam int S_BITS = $clog2(STEPS + 1);

   logic [P_BITS-1:0] acc_ff, acc_in;
   logic [P_BITS-1:0] a_ff, a_in;
   logic [B_BITS-1:0] b_ff, b_in;
   logic [S_BITS-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   always_comb begin
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         a_in    = P_BITS'(a);
         b_in    = b;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in  = acc_ff + P_BITS'(a_ff * b_ff[MUL_DIGIT-1:0]);
         a_in    = a_ff << MUL_DIGIT;
         b_in    = b_ff >> MUL_DIGIT;
         step_in = step_ff + 1'b1;
         if (step_ff == S_BITS'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

[hw/rtl/convex_hull_gift_wrap.sv]
// ----------------------------------------------------------------------------
// convex_hull_gift_wrap
// Jarvis march convex hull over a set of loaded signed points.
// ----------------------------------------------------------------------------
// Points are loaded one transaction per cycle into a two-port point memory.
// The transaction that carries last_point starts the hull run; the block then
// stalls its input until the final vertex has been placed in the output
// register. The start vertex (lowest y, then lowest x) is tracked during the
// load, so the run begins at once. Each further vertex costs one full scan of
// the stored points through the memory read port: a point equal to the
// current vertex is dropped once it has been read and differenced; any other
// point passes through dot product, squared length and squared dot, and is
// decided at the compare when it is the first candidate or its cosine sign
// differs from the best so far, else after two exact cross-multiplied products.
// That per-point cost is set by the shared serial multiplier, which retires
// eight multiplier bits per cycle and is waited on for every product. A run
// emits at most as many vertices as points.
// Results are held in an output register, so a stall on the result channel
// only pauses the walk when a second vertex is ready.
// ----------------------------------------------------------------------------
module convex_hull_gift_wrap #(
   parameter int MAX_POINTS = 64,
   parameter int COORD_BITS = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [COORD_BITS-1:0]            req_point_x,
   input  logic signed [COORD_BITS-1:0]            req_point_y,
   input  logic                                    req_last_point,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [COORD_BITS-1:0]            rsp_vertex_x,
   output logic signed [COORD_BITS-1:0]            rsp_vertex_y,
   output logic [chgw_pkg::VERTEX_INDEX_BITS-1:0]  rsp_vertex_index,
   output logic                                    rsp_last_vertex
);
   import chgw_pkg::*;

   localparam int CB  = COORD_BITS;
   localparam int IW  = $clog2(MAX_POINTS);
   localparam int CW  = $clog2(MAX_POINTS + 1);
   localparam int DW  = CB + 1;          // coordinate difference
   localparam int PW  = 2 * DW + 1;      // signed dot product
   localparam int MW  = 2 * CB + 2;      // dot magnitude and squared length
   localparam int AW  = 2 * MW;          // squared dot magnitude
   localparam int PRW = AW + MW;         // cross-multiplied product

   localparam logic [3:0] S_LOAD = 4'd0;
   localparam logic [3:0] S_INIT = 4'd1;
   localparam logic [3:0] S_RD   = 4'd2;
   localparam logic [3:0] S_DIFF = 4'd3;
   localparam logic [3:0] S_DOT  = 4'd4;
   localparam logic [3:0] S_LEN  = 4'd5;
   localparam logic [3:0] S_SQ   = 4'd6;
   localparam logic [3:0] S_SQW  = 4'd7;
   localparam logic [3:0] S_CMP  = 4'd8;
   localparam logic [3:0] S_LW   = 4'd9;
   localparam logic [3:0] S_RW   = 4'd10;
   localparam logic [3:0] S_DEC  = 4'd11;
   localparam logic [3:0] S_EMIT = 4'd12;

   // Point memory: x in the upper half of a word, y in the lower half.
   logic [2*CB-1:0] point_mem [MAX_POINTS];
   logic [2*CB-1:0] rdata_ff;

   logic [3:0]            state_ff, state_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [CW-1:0]         i_ff, i_in;
   logic [CW-1:0]         emit_ff, emit_in;
   logic [IW-1:0]         st_idx_ff, st_idx_in;
   logic signed [CB-1:0]  st_x_ff, st_x_in, st_y_ff, st_y_in;
   logic signed [CB-1:0]  cx_ff, cx_in, cy_ff, cy_in;
   logic signed [CB-1:0]  rx_ff, rx_in, ry_ff, ry_in;
   logic signed [CB-1:0]  bx_ff, bx_in, by_ff, by_in;
   logic signed [CB-1:0]  pend_x_ff, pend_x_in, pend_y_ff, pend_y_in;
   logic [IW-1:0]         pend_idx_ff, pend_idx_in;
   logic signed [DW-1:0]  dx_ff, dx_in, dy_ff, dy_in;
   logic signed [DW-1:0]  vx_ff, vx_in, vy_ff, vy_in;
   logic signed [2*DW-1:0] p1_ff, p1_in, p2_ff, p2_in;
   logic signed [PW-1:0]  d_ff, d_in, bd_ff, bd_in;
   logic [MW-1:0]         l_ff, l_in, bl_ff, bl_in;
   logic [AW-1:0]         sq_ff, sq_in, bsq_ff, bsq_in;
   logic [PRW-1:0]        lhs_ff, lhs_in;
   logic                  have_ff, have_in;
   logic [IW-1:0]         bidx_ff, bidx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [CB-1:0]  ox_ff, ox_in, oy_ff, oy_in;
   logic [IW-1:0]         oidx_ff, oidx_in;
   logic                  olast_ff, olast_in;

   logic                  mul_start;
   logic [AW-1:0]         mul_a;
   logic [MW-1:0]         mul_b;
   logic                  mul_done;
   logic [PRW-1:0]        mul_prod;

   logic                  load_acc;
   logic                  store_ok;
   logic                  out_free;
   logic                  step;
   logic                  take;
   logic signed [CB-1:0]  mem_x, mem_y;
   logic signed [DW-1:0]  diff_x, diff_y;
   logic [MW-1:0]         dmag;
   logic                  dneg, bneg;

   chgw_mul #(
      .A_BITS (AW),
      .B_BITS (MW)
   ) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   assign req_stall = (state_ff != S_LOAD);
   assign load_acc  = req_valid && !req_stall;
   assign store_ok  = (cnt_ff < CW'(MAX_POINTS));
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign mem_x  = rdata_ff[2*CB-1:CB];
   assign mem_y  = rdata_ff[CB-1:0];
   assign diff_x = DW'(mem_x) - DW'(cx_ff);
   assign diff_y = DW'(mem_y) - DW'(cy_ff);
   assign dneg   = d_ff[PW-1];
   assign bneg   = bd_ff[PW-1];
   assign dmag   = dneg ? MW'(-d_ff) : MW'(d_ff);

   // Point memory: one write port for loading, one registered read for scans.
   always_ff @(posedge clock) begin
      if (load_acc && store_ok) begin
         point_mem[cnt_ff[IW-1:0]] <= {req_point_x, req_point_y};
      end
      rdata_ff <= point_mem[i_ff[IW-1:0]];
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      i_in         = i_ff;
      emit_in      = emit_ff;
      st_idx_in    = st_idx_ff;
      st_x_in      = st_x_ff;
      st_y_in      = st_y_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      rx_in        = rx_ff;
      ry_in        = ry_ff;
      bx_in        = bx_ff;
      by_in        = by_ff;
      pend_x_in    = pend_x_ff;
      pend_y_in    = pend_y_ff;
      pend_idx_in  = pend_idx_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      p1_in        = p1_ff;
      p2_in        = p2_ff;
      d_in         = d_ff;
      bd_in        = bd_ff;
      l_in         = l_ff;
      bl_in        = bl_ff;
      sq_in        = sq_ff;
      bsq_in       = bsq_ff;
      lhs_in       = lhs_ff;
      have_in      = have_ff;
      bidx_in      = bidx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ox_in        = ox_ff;
      oy_in        = oy_ff;
      oidx_in      = oidx_ff;
      olast_in     = olast_ff;
      mul_start    = 1'b0;
      mul_a        = AW'(dmag);
      mul_b        = dmag;
      step         = 1'b0;
      take         = 1'b0;

      case (state_ff)
         S_LOAD: begin
            if (load_acc) begin
               if (store_ok) begin
                  cnt_in = cnt_ff + 1'b1;
                  // Lowest y wins, then lowest x; ties keep the earlier point.
                  if (cnt_ff == '0 || req_point_y < st_y_ff ||
                      (req_point_y == st_y_ff && req_point_x < st_x_ff)) begin
                     st_idx_in = cnt_ff[IW-1:0];
                     st_x_in   = req_point_x;
                     st_y_in   = req_point_y;
                  end
               end
               if (req_last_point) begin
                  state_in = S_INIT;
               end
            end
         end
         S_INIT: begin
            pend_x_in   = st_x_ff;
            pend_y_in   = st_y_ff;
            pend_idx_in = st_idx_ff;
            cx_in       = st_x_ff;
            cy_in       = st_y_ff;
            dx_in       = DW'(1);
            dy_in       = '0;
            emit_in     = CW'(1);
            i_in        = '0;
            have_in     = 1'b0;
            state_in    = (cnt_ff == CW'(1)) ? S_EMIT : S_RD;
         end
         S_RD: begin
            state_in = S_DIFF;
         end
         S_DIFF: begin
            rx_in = mem_x;
            ry_in = mem_y;
            vx_in = diff_x;
            vy_in = diff_y;
            if (diff_x == '0 && diff_y == '0) begin
               step = 1'b1;
            end else begin
               state_in = S_DOT;
            end
         end
         S_DOT: begin
            p1_in    = dx_ff * vx_ff;
            p2_in    = dy_ff * vy_ff;
            state_in = S_LEN;
         end
         S_LEN: begin
            d_in     = PW'(p1_ff) + PW'(p2_ff);
            p1_in    = vx_ff * vx_ff;
            p2_in    = vy_ff * vy_ff;
            state_in = S_SQ;
         end
         S_SQ: begin
            l_in      = MW'($unsigned(p1_ff)) + MW'($unsigned(p2_ff));
            mul_start = 1'b1;
            state_in  = S_SQW;
         end
         S_SQW: begin
            if (mul_done) begin
               sq_in    = mul_prod[AW-1:0];
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (!have_ff) begin
               take = 1'b1;
               step = 1'b1;
            end else if (dneg != bneg) begin
               take = !dneg;
               step = 1'b1;
            end else begin
               mul_start = 1'b1;
               mul_a     = sq_ff;
               mul_b     = bl_ff;
               state_in  = S_LW;
            end
         end
         S_LW: begin
            mul_a = bsq_ff;
            mul_b = l_ff;
            if (mul_done) begin
               lhs_in    = mul_prod;
               mul_start = 1'b1;
               state_in  = S_RW;
            end
         end
         S_RW: begin
            if (mul_done) begin
               // Both cosines share a sign; for negatives the order flips.
               take = dneg ? (lhs_ff < mul_prod) : (lhs_ff > mul_prod);
               step = 1'b1;
            end
         end
         S_DEC: begin
            if (!have_ff || bidx_ff == st_idx_ff) begin
               state_in = S_EMIT;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               ox_in        = pend_x_ff;
               oy_in        = pend_y_ff;
               oidx_in      = pend_idx_ff;
               olast_in     = 1'b0;
               pend_x_in    = bx_ff;
               pend_y_in    = by_ff;
               pend_idx_in  = bidx_ff;
               cx_in        = bx_ff;
               cy_in        = by_ff;
               dx_in        = DW'(bx_ff) - DW'(cx_ff);
               dy_in        = DW'(by_ff) - DW'(cy_ff);
               emit_in      = emit_ff + 1'b1;
               i_in         = '0;
               have_in      = 1'b0;
               state_in     = (emit_ff + 1'b1 == cnt_ff) ? S_EMIT : S_RD;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               ox_in        = pend_x_ff;
               oy_in        = pend_y_ff;
               oidx_in      = pend_idx_ff;
               olast_in     = 1'b1;
               cnt_in       = '0;
               state_in     = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase

      // Close out one candidate and move the scan on.
      if (step) begin
         if (take) begin
            have_in = 1'b1;
            bd_in   = d_ff;
            bl_in   = l_ff;
            bsq_in  = sq_ff;
            bidx_in = i_ff[IW-1:0];
            bx_in   = rx_ff;
            by_in   = ry_ff;
         end
         if (i_ff + 1'b1 < cnt_ff) begin
            i_in     = i_ff + 1'b1;
            state_in = S_RD;
         end else begin
            state_in = S_DEC;
         end
      end
   end

   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      st_idx_ff   <= st_idx_in;
      st_x_ff     <= st_x_in;
      st_y_ff     <= st_y_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      rx_ff       <= rx_in;
      ry_ff       <= ry_in;
      bx_ff       <= bx_in;
      by_ff       <= by_in;
      pend_x_ff   <= pend_x_in;
      pend_y_ff   <= pend_y_in;
      pend_idx_ff <= pend_idx_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      vx_ff       <= vx_in;
      vy_ff       <= vy_in;
      p1_ff       <= p1_in;
      p2_ff       <= p2_in;
      d_ff        <= d_in;
      bd_ff       <= bd_in;
      l_ff        <= l_in;
      bl_ff       <= bl_in;
      sq_ff       <= sq_in;
      bsq_ff      <= bsq_in;
      lhs_ff      <= lhs_in;
      bidx_ff     <= bidx_in;
      ox_ff       <= ox_in;
      oy_ff       <= oy_in;
      oidx_ff     <= oidx_in;
      olast_ff    <= olast_in;
      if (reset) begin
         state_ff     <= S_LOAD;
         cnt_ff       <= '0;
         emit_ff      <= '0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         emit_ff      <= emit_in;
         have_ff      <= have_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_vertex_x     = ox_ff;
   assign rsp_vertex_y     = oy_ff;
   assign rsp_vertex_index = VERTEX_INDEX_BITS'(oidx_ff);
   assign rsp_last_vertex  = olast_ff;

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_POINTS))
      else $error("point count exceeds the store depth");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RD |-> i_ff < cnt_ff)
      else $error("scan reads beyond the loaded points");

   // The vertex count of the previous run is still held while a run starts.
   a_emit_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_LOAD && state_ff != S_INIT) |-> emit_ff <= cnt_ff)
      else $error("more vertices than points in one run");

   a_mul_owner: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == S_SQW || state_ff == S_LW || state_ff == S_RW))
      else $error("product finished outside a wait state");

   a_run_ends_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && out_free) |=> rsp_valid && rsp_last_vertex)
      else $error("run closed without a final vertex");
`endif

endmodule
